@@ rtl/core/acf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_pkg
// Shared constants, tables and helpers of the attitude complementary filter.
// ----------------------------------------------------------------------------
package acf_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_N           = 24;
  localparam int ATAN_IW          = $clog2(ATAN_N);
  localparam int TAB_SH           = 30 - FRAC_BITS;

  localparam int DIV_W     = 57;
  localparam int DIV_SH    = 57;
  localparam int DIV_ACC_W = DIV_W + 48;
  localparam int DIV_PP    = 4;
  localparam int DIV_K     = 1000;
  localparam logic [47:0] DIV_RECIP = 48'd144115188075855;
  localparam logic [63:0] DIV_HALF  = 64'd500;

  localparam int SQ_STEPS = 32;
  localparam int SQ_CW    = $clog2(SQ_STEPS + 1);

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [32:0] DEG_Q24 = 33'sd961263669;

  localparam logic [31:0] ATAN_Q30 [0:ATAN_N-1] = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128
  };

  typedef enum logic [1:0] {
    REG_BIAS_X = 2'd0,
    REG_BIAS_Y = 2'd1,
    REG_BIAS_Z = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_t;

  function automatic logic [31:0] frac_of(input logic [31:0] t);
    logic [32:0] s;
    s = {1'b0, t} + (33'd1 << (TAB_SH - 1));
    s = s >> TAB_SH;
    return s[31:0];
  endfunction

  function automatic logic [31:0] atan_frac(input logic [ATAN_IW-1:0] i);
    logic [31:0] v;
    v = 32'd0;
    if (int'(i) < ATAN_N) begin
      v = frac_of(ATAN_Q30[i]);
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/acf_div1k.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_div1k
// Divide by 1000 through a reciprocal: four 32x32 partial products are
// accumulated, then one compare step fixes the estimate.
// ----------------------------------------------------------------------------
module acf_div1k
  import acf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [2:0]           cnt_r;
  logic [DIV_W-1:0]     n_r;
  logic [DIV_ACC_W-1:0] acc_r;
  logic [DIV_W-1:0]     quo_r;
  logic [31:0]          ma;
  logic [31:0]          mb;
  logic [63:0]          pp;
  logic [DIV_ACC_W-1:0] pp_sh;
  logic [DIV_W-1:0]     q0;
  logic [DIV_W-1:0]     q0_k;
  logic [DIV_W-1:0]     rem;

  always_comb begin
    case (cnt_r)
      3'd0: begin
        ma = n_r[31:0];
        mb = DIV_RECIP[31:0];
      end
      3'd1: begin
        ma = n_r[31:0];
        mb = 32'(DIV_RECIP[47:32]);
      end
      3'd2: begin
        ma = 32'(n_r[DIV_W-1:32]);
        mb = DIV_RECIP[31:0];
      end
      3'd3: begin
        ma = 32'(n_r[DIV_W-1:32]);
        mb = 32'(DIV_RECIP[47:32]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign pp = ma * mb;

  always_comb begin
    case (cnt_r)
      3'd0:       pp_sh = DIV_ACC_W'(pp);
      3'd1, 3'd2: pp_sh = DIV_ACC_W'(pp) << 32;
      3'd3:       pp_sh = DIV_ACC_W'(pp) << 64;
      default:    pp_sh = '0;
    endcase
  end

  // estimate is exact or one low
  assign q0   = DIV_W'(acc_r >> DIV_SH);
  assign q0_k = (q0 << 10) - (q0 << 4) - (q0 << 3);
  assign rem  = n_r - q0_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'(DIV_PP)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'(DIV_PP)) begin
        quo_r <= (rem >= DIV_W'(DIV_K)) ? q0 + DIV_W'(1) : q0;
      end else begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/acf_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_isqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module acf_isqrt
  import acf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic             busy_r;
  logic             done_r;
  logic [SQ_CW-1:0] cnt_r;
  logic [63:0]      n_r;
  logic [63:0]      res_r;
  logic [63:0]      bit_r;
  logic [63:0]      sum;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CW'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (n_r >= sum) begin
        n_r   <= n_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

@@ rtl/core/acf_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_cordic
// Iterative vectoring CORDIC giving atan2(y, x), one rotation per cycle.
// ----------------------------------------------------------------------------
module acf_cordic
  import acf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] x_in,
  output logic               done,
  output logic signed [31:0] angle
);

  localparam int VW = 36;

  logic                     busy_r;
  logic                     done_r;
  logic [ATAN_IW-1:0]       i_r;
  logic signed [VW-1:0]     x_r;
  logic signed [VW-1:0]     y_r;
  logic signed [31:0]       z_r;
  logic signed [VW-1:0]     xs;
  logic signed [VW-1:0]     ys;
  logic signed [VW-1:0]     x0;
  logic signed [VW-1:0]     y0;
  logic signed [31:0]       a;
  logic signed [31:0]       pi_f;
  logic                     zero_in;

  assign x0      = VW'(x_in);
  assign y0      = VW'(y_in);
  assign zero_in = (x_in == '0) && (y_in == '0);
  assign xs      = x_r >>> i_r;
  assign ys      = y_r >>> i_r;
  assign a       = $signed(atan_frac(i_r));
  assign pi_f    = $signed(frac_of(PI_Q30));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (zero_in) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == ATAN_IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (zero_in) begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end else if (x0 < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= (y0 >= 0) ? pi_f : -pi_f;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + a;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - a;
      end
    end
  end

  assign done  = done_r;
  assign angle = z_r;

endmodule

@@ rtl/core/imu_attitude_complementary_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_top
// Roll/pitch/yaw complementary filter over one shared multiplier, a reciprocal
// divider by 1000, an iterative square root and an iterative CORDIC.
// Each result waits on the 32-step square root and the two CORDIC passes; a
//   CORDIC pass whose input vector is zero skips its rotations.
// Throughput: one transaction at a time; in_stall is high until the result
//   transaction is taken.
// Reset (synchronous, rst_n low): angles and last timestamp cleared, biases
//   zero, blend gain 6554, no result pending.
// ----------------------------------------------------------------------------
module imu_attitude_complementary_filter_top
  import acf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_gyro_x,
  input  logic signed [23:0] in_gyro_y,
  input  logic signed [23:0] in_gyro_z,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic        [31:0] in_time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_roll_deg,
  output logic signed [31:0] out_pitch_deg,
  output logic signed [31:0] out_yaw_deg,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic        [3:0]  cfg_paddr,
  input  logic        [31:0] cfg_pwdata,
  output logic        [31:0] cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_IMUL = 11'b00000000010,
    ST_IDIV = 11'b00000000100,
    ST_SQ   = 11'b00000001000,
    ST_SQRT = 11'b00000010000,
    ST_CORD = 11'b00000100000,
    ST_BMUL = 11'b00001000000,
    ST_BADD = 11'b00010000000,
    ST_DMUL = 11'b00100000000,
    ST_DADD = 11'b01000000000,
    ST_OUT  = 11'b10000000000
  } st_t;

  st_t                state_r, state_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               go_r, go_nxt;

  logic signed [23:0] bias_r [0:2];
  logic        [15:0] gain_r;

  logic signed [24:0] rate_r [0:2];
  logic signed [15:0] ax_r, ay_r, az_r;
  logic        [31:0] dt_r;
  logic        [31:0] last_r;
  logic signed [31:0] ang_r [0:2];
  logic signed [31:0] deg_r [0:2];
  logic        [31:0] sq_r;
  logic        [31:0] root_r;
  logic signed [63:0] prod_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic               in_acc;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  logic [63:0]        mag;
  logic [DIV_W-1:0]   div_in;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic signed [63:0] q_s;

  logic               sq_done;
  logic [31:0]        sq_root;

  logic               cor_done;
  logic signed [31:0] cor_z;
  logic signed [33:0] cor_y, cor_x;

  logic signed [63:0] blend_t;
  logic signed [63:0] deg_t;
  logic signed [15:0] sq_src;

  assign in_acc  = in_valid && !in_stall;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = reg_idx_t'(cfg_paddr[3:2]);

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r[0] <= '0;
      bias_r[1] <= '0;
      bias_r[2] <= '0;
      gain_r    <= 16'd6554;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BIAS_X: bias_r[0] <= cfg_pwdata[23:0];
        REG_BIAS_Y: bias_r[1] <= cfg_pwdata[23:0];
        REG_BIAS_Z: bias_r[2] <= cfg_pwdata[23:0];
        REG_GAIN:   gain_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BIAS_X: cfg_prdata = {8'b0, bias_r[0]};
      REG_BIAS_Y: cfg_prdata = {8'b0, bias_r[1]};
      REG_BIAS_Z: cfg_prdata = {8'b0, bias_r[2]};
      REG_GAIN:   cfg_prdata = {16'b0, gain_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // shared multiplier
  assign sq_src = (idx_r == 2'd0) ? ay_r : az_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_IMUL: begin
        mul_a = 33'(rate_r[idx_r]);
        mul_b = $signed({1'b0, dt_r});
      end
      ST_SQ: begin
        mul_a = 33'(sq_src);
        mul_b = 33'(sq_src);
      end
      ST_BMUL: begin
        mul_a = 33'(cor_z) - 33'(ang_r[idx_r]);
        mul_b = $signed({17'b0, gain_r});
      end
      ST_DMUL: begin
        mul_a = 33'(ang_r[idx_r]);
        mul_b = DEG_Q24;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sub-units
  assign mag    = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign div_in = DIV_W'(mag + DIV_HALF);
  assign q_s    = prod_r[63] ? -$signed({7'b0, quo}) : $signed({7'b0, quo});

  acf_div1k u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r && (state_r == ST_IDIV)),
    .dividend (div_in),
    .done     (div_done),
    .quotient (quo)
  );

  acf_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r && (state_r == ST_SQRT)),
    .radicand ({sq_r, 32'b0}),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign cor_y = (idx_r == 2'd0) ? $signed({{2{ay_r[15]}}, ay_r, 16'b0})
                                 : -$signed({{2{ax_r[15]}}, ax_r, 16'b0});
  assign cor_x = (idx_r == 2'd0) ? $signed({{2{az_r[15]}}, az_r, 16'b0})
                                 : $signed({2'b0, root_r});

  acf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r && (state_r == ST_CORD)),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_z)
  );

  assign blend_t = (prod_r + 64'sd32768) >>> 16;
  assign deg_t   = (prod_r + 64'sd8388608) >>> 24;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    go_nxt    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_IMUL;
          idx_nxt   = 2'd0;
        end
      end
      ST_IMUL: begin
        state_nxt = ST_IDIV;
        go_nxt    = 1'b1;
      end
      ST_IDIV: begin
        if (!go_r && div_done) begin
          if (idx_r == 2'd2) begin
            state_nxt = ST_SQ;
            idx_nxt   = 2'd0;
          end else begin
            state_nxt = ST_IMUL;
            idx_nxt   = idx_r + 2'd1;
          end
        end
      end
      ST_SQ: begin
        if (idx_r == 2'd0) begin
          idx_nxt = 2'd1;
        end else begin
          state_nxt = ST_SQRT;
          idx_nxt   = 2'd0;
          go_nxt    = 1'b1;
        end
      end
      ST_SQRT: begin
        if (!go_r && sq_done) begin
          state_nxt = ST_CORD;
          go_nxt    = 1'b1;
        end
      end
      ST_CORD: begin
        if (!go_r && cor_done) begin
          state_nxt = ST_BMUL;
        end
      end
      ST_BMUL: state_nxt = ST_BADD;
      ST_BADD: begin
        if (idx_r == 2'd0) begin
          state_nxt = ST_CORD;
          idx_nxt   = 2'd1;
          go_nxt    = 1'b1;
        end else begin
          state_nxt = ST_DMUL;
          idx_nxt   = 2'd0;
        end
      end
      ST_DMUL: state_nxt = ST_DADD;
      ST_DADD: begin
        if (idx_r == 2'd2) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DMUL;
          idx_nxt   = idx_r + 2'd1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      go_r    <= go_nxt;
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
      last_r   <= '0;
    end else begin
      if (in_acc) begin
        last_r <= in_time_ms;
      end
      if (state_r == ST_IDIV && !go_r && div_done) begin
        ang_r[idx_r] <= sat32(64'(ang_r[idx_r]) + q_s);
      end
      if (state_r == ST_BADD) begin
        ang_r[idx_r] <= sat32(64'(ang_r[idx_r]) + blend_t);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r[0] <= 25'(in_gyro_x) - 25'(bias_r[0]);
      rate_r[1] <= 25'(in_gyro_y) - 25'(bias_r[1]);
      rate_r[2] <= 25'(in_gyro_z) - 25'(bias_r[2]);
      ax_r      <= in_accel_x;
      ay_r      <= in_accel_y;
      az_r      <= in_accel_z;
      dt_r      <= in_time_ms - last_r;
    end
    case (state_r)
      ST_IMUL, ST_BMUL, ST_DMUL: prod_r <= mul_p[63:0];
      ST_SQ:   sq_r <= ((idx_r == 2'd0) ? 32'd0 : sq_r) + mul_p[31:0];
      ST_SQRT: root_r <= sq_root;
      ST_DADD: deg_r[idx_r] <= sat32(deg_t);
      default: ;
    endcase
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_roll_deg  = deg_r[0];
  assign out_pitch_deg = deg_r[1];
  assign out_yaw_deg   = deg_r[2];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted transaction did not make the block busy");

  a_result_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result pending while input side open");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !in_stall && !out_valid)
    else $error("block not idle after result transaction");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the roll/pitch/yaw complementary filter. A driver
// feeds IMU samples from a queue, a bit-exact attitude predictor works out the
// angles of every accepted transaction, and a monitor checks each result in
// order. Bias and blend gain are reprogrammed between phases, with random
// idling on both channels outside the calm phase.
// ----------------------------------------------------------------------------
module tb
  import acf_pkg::*;
();

  typedef struct packed {
    logic signed [23:0] gx, gy, gz;
    logic signed [15:0] ax, ay, az;
    logic        [31:0] t;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] roll, pitch, yaw;
  } attitude_t;

  localparam longint ATAN_TAB [0:23] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128};
  localparam longint PI_TAB = 64'd3373259426;
  localparam longint RAD2DEG_Q24 = 961263669;
  localparam int LIMIT = 1500000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [23:0] in_gyro_x, in_gyro_y, in_gyro_z;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic [31:0] in_time_ms;
  logic signed [31:0] out_roll_deg, out_pitch_deg, out_yaw_deg;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  imu_sample_t pending_q[$];
  attitude_t   expected_q[$];
  imu_sample_t cur;
  logic        hold_off, calm;
  int          cycles, errors, n_sent, n_checked, n_cfg;

  // predictor state
  longint bias_x, bias_y, bias_z, gain;
  longint roll_a, pitch_a, yaw_a;
  logic [31:0] last_t;

  imu_attitude_complementary_filter_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint tab_frac(longint t);
    return (t + (64'sd1 <<< 13)) >>> 14;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? tab_frac(PI_TAB) : -tab_frac(PI_TAB);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + tab_frac(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - tab_frac(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint integrate_rate(longint ang, longint rate, logic [31:0] dt);
    longint p, q;
    p = rate * longint'({32'd0, dt});
    q = ((p < 0 ? -p : p) + 500) / 1000;
    if (p < 0) q = -q;
    return clamp32(ang + q);
  endfunction

  function automatic longint pull_toward(longint ang, longint target);
    return clamp32(ang + (((target - ang) * gain + (64'sd1 <<< 15)) >>> 16));
  endfunction

  function automatic logic signed [31:0] rad_to_deg(longint ang);
    return 32'(clamp32((ang * RAD2DEG_Q24 + (64'sd1 <<< 23)) >>> 24));
  endfunction

  function automatic void predict_attitude(imu_sample_t s);
    logic [31:0] dt;
    longint ax, ay, az, r;
    attitude_t e;
    dt = s.t - last_t;
    last_t = s.t;
    ax = s.ax; ay = s.ay; az = s.az;
    roll_a  = integrate_rate(roll_a,  longint'(s.gx) - bias_x, dt);
    pitch_a = integrate_rate(pitch_a, longint'(s.gy) - bias_y, dt);
    yaw_a   = integrate_rate(yaw_a,   longint'(s.gz) - bias_z, dt);
    r = longint'(int_sqrt(longint'(ay * ay + az * az) << 32));
    roll_a  = pull_toward(roll_a,  vector_angle(ay * 65536, az * 65536));
    pitch_a = pull_toward(pitch_a, vector_angle(-ax * 65536, r));
    e.roll = rad_to_deg(roll_a);
    e.pitch = rad_to_deg(pitch_a);
    e.yaw = rad_to_deg(yaw_a);
    expected_q.push_back(e);
  endfunction

  // driver: acceptance seen at posedge, next transaction driven at negedge
  logic took;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_attitude(cur);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (hold_off || pending_q.size() == 0 || (!calm && $urandom_range(99) < 21)) begin
        in_valid <= 1'b0;
      end else begin
        cur = pending_q.pop_front();
        n_sent++;
        in_gyro_x <= cur.gx; in_gyro_y <= cur.gy; in_gyro_z <= cur.gz;
        in_accel_x <= cur.ax; in_accel_y <= cur.ay; in_accel_z <= cur.az;
        in_time_ms <= cur.t;
        in_valid <= 1'b1;
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 21);
  end

  // monitor
  always @(posedge clk) begin
    attitude_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction");
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.roll !== out_roll_deg || e.pitch !== out_pitch_deg ||
            e.yaw !== out_yaw_deg) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp r/p/y %0d %0d %0d got %0d %0d %0d",
                     n_checked, e.roll, e.pitch, e.yaw,
                     out_roll_deg, out_pitch_deg, out_yaw_deg);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[imu_attitude_complementary_filter_top] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_BIAS_X: bias_x = longint'($signed(v[23:0]));
      REG_BIAS_Y: bias_y = longint'($signed(v[23:0]));
      REG_BIAS_Z: bias_z = longint'($signed(v[23:0]));
      REG_GAIN:   gain = longint'({48'd0, v[15:0]});
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic drain();
    while (pending_q.size() != 0)
      @(posedge clk);
    hold_off = 1'b1;
    while (expected_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  endtask

  task automatic add(logic [23:0] gx, gy, gz, logic [15:0] ax, ay, az, logic [31:0] t);
    imu_sample_t s;
    s.gx = gx; s.gy = gy; s.gz = gz; s.ax = ax; s.ay = ay; s.az = az; s.t = t;
    pending_q.push_back(s);
  endtask

  task automatic add_random(int n, ref logic [31:0] t);
    logic [23:0] g [3];
    int m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(99);
      for (int a = 0; a < 3; a++)
        g[a] = (m < 70) ? 24'($signed($urandom_range(131072)) - 65536) : 24'($urandom);
      if (m < 85) t = t + $urandom_range(1, 20);
      else if (m < 95) t = $urandom;
      else t = t + $urandom_range(0, 100000);
      add(g[0], g[1], g[2], 16'($urandom), 16'($urandom), 16'($urandom), t);
    end
  endtask

  initial begin
    logic [31:0] t;
    rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; took = 1'b0;
    in_gyro_x = '0; in_gyro_y = '0; in_gyro_z = '0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0; in_time_ms = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    hold_off = 1'b0; calm = 1'b0;
    cycles = 0; errors = 0; n_sent = 0; n_checked = 0; n_cfg = 0;
    bias_x = 0; bias_y = 0; bias_z = 0; gain = 6554;
    roll_a = 0; pitch_a = 0; yaw_a = 0; last_t = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: first sample, zero vector, quadrants, saturation, wrap
    add(24'sd65536, -24'sd65536, 24'sd1000, 16'sd0, 16'sd0, 16'sd0, 32'd1234);
    add(24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'd1244);
    add(24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd100, -16'sd16384, 32'd1254);
    add(24'sd0, 24'sd0, 24'sd0, 16'sd0, -16'sd100, -16'sd16384, 32'd1264);
    add(24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, -16'sd16384, 32'd1274);
    add(24'sd0, 24'sd0, 24'sd0, 16'h7fff, 16'sd0, 16'sd0, 32'd1284);
    add(24'sd0, 24'sd0, 24'sd0, 16'h8000, 16'h8000, 16'h8000, 32'd1294);
    add(24'sd0, 24'sd0, 24'sd0, 16'h7fff, 16'h7fff, 16'h7fff, 32'd1304);
    add(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'sd0, 16'sd0, 16'sd1, 32'hffffff00);
    add(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'sd0, 16'sd0, 16'sd1, 32'hfffffff0);
    add(24'h800000, 24'h800000, 24'h800000, 16'sd0, 16'sd0, -16'sd1, 32'h00000010);
    add(24'h800000, 24'h800000, 24'h800000, 16'sd5, -16'sd7, 16'sd0, 32'h7ffffff0);
    add(24'h800000, 24'h800000, 24'h800000, 16'sd5, -16'sd7, 16'sd0, 32'hfffffff0);
    add(24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hfffffff0);
    add(24'sd300, -24'sd300, 24'sd0, 16'sd10, 16'sd0, 16'sd16000, 32'hffffffff);
    add(24'sd300, -24'sd300, 24'sd0, 16'sd10, 16'sd0, 16'sd16000, 32'd3);
    drain();

    t = 32'd100;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_BIAS_X, 32'h007fffff); cfg_write(REG_BIAS_Y, 32'h00800000);
          cfg_write(REG_BIAS_Z, 32'd0); cfg_write(REG_GAIN, 32'd0);
        end
        1: begin
          cfg_write(REG_BIAS_X, 32'h00800000); cfg_write(REG_BIAS_Y, 32'h007fffff);
          cfg_write(REG_BIAS_Z, 32'h007fffff); cfg_write(REG_GAIN, 32'd65535);
        end
        2: begin
          calm = 1'b1;
          cfg_write(REG_BIAS_X, $urandom); cfg_write(REG_BIAS_Y, $urandom);
          cfg_write(REG_BIAS_Z, $urandom); cfg_write(REG_GAIN, $urandom);
        end
        3: begin
          cfg_write(REG_BIAS_X, 32'd0); cfg_write(REG_BIAS_Y, 32'd0);
          cfg_write(REG_BIAS_Z, 32'h00800000); cfg_write(REG_GAIN, 32'd6554);
        end
        default: begin
          cfg_write(REG_BIAS_X, $urandom_range(2000)); cfg_write(REG_BIAS_Y, 32'd7);
          cfg_write(REG_BIAS_Z, $urandom_range(2000)); cfg_write(REG_GAIN, $urandom);
        end
      endcase
      add_random(180, t);
      drain();
      calm = 1'b0;
    end

    $display("checked %0d of %0d samples over %0d register writes, %0d cycles",
             n_checked, n_sent, n_cfg, cycles);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[imu_attitude_complementary_filter_top] OK");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_q.size());
      $display("[imu_attitude_complementary_filter_top] ERROR");
    end
    $finish;
  end

endmodule
